[design/bq_pkg.sv]
// ----------------------------------------------------------------------------
// bq_pkg: shared types and constants of the biquad filter
// Coefficient set, register indexes, command codes and fixed datapath widths.
// ----------------------------------------------------------------------------
package bq_pkg;

	localparam int COEF_W    = 32;
	localparam int HIST_W    = 32;
	localparam int HIST_FRAC = 16;
	localparam int CFG_IDX_W = 3;
	// wide enough for the exact five-term sum at any sample width up to 32 bits
	localparam int ACC_W     = 66;
	localparam int ACC_LIM_BIT = 61;

	localparam logic [CFG_IDX_W-1:0] CFG_B0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_B1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_B2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_A1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_A2 = 3'd4;

	localparam logic CMD_PRIME  = 1'b0;
	localparam logic CMD_FILTER = 1'b1;

	// low-pass defaults, Q2.30
	localparam logic signed [COEF_W-1:0] RST_B0 = 32'sd259157;
	localparam logic signed [COEF_W-1:0] RST_B1 = 32'sd518315;
	localparam logic signed [COEF_W-1:0] RST_B2 = 32'sd259157;
	localparam logic signed [COEF_W-1:0] RST_A1 = -32'sd2099788036;
	localparam logic signed [COEF_W-1:0] RST_A2 = 32'sd1027081299;

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} bq_coef_t;

endpackage

[design/bq_coef_regs.sv]
// ----------------------------------------------------------------------------
// bq_coef_regs: coefficient register file
// Five Q2.30 coefficients, written by index, reset to the low-pass set.
// ----------------------------------------------------------------------------
module bq_coef_regs
	import bq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [COEF_W-1:0]    wr_data,
	output bq_coef_t             coef
);

	bq_coef_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= RST_B0;
			coef_q.b1 <= RST_B1;
			coef_q.b2 <= RST_B2;
			coef_q.a1 <= RST_A1;
			coef_q.a2 <= RST_A2;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_B0:  coef_q.b0 <= wr_data;
				CFG_B1:  coef_q.b1 <= wr_data;
				CFG_B2:  coef_q.b2 <= wr_data;
				CFG_A1:  coef_q.a1 <= wr_data;
				CFG_A2:  coef_q.a2 <= wr_data;
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

[design/bq_datapath.sv]
// ----------------------------------------------------------------------------
// bq_datapath: biquad arithmetic for one sample
// Five products, exact sum, clamp, rounding to output and Q16.16 history.
// ----------------------------------------------------------------------------
module bq_datapath
	import bq_pkg::*;
#(
	parameter int SAMPLE_BITS    = 16,
	parameter int COEF_FRAC_BITS = 30
) (
	input  bq_coef_t                        coef,
	input  logic signed [SAMPLE_BITS-1:0]   sample,
	input  logic signed [SAMPLE_BITS-1:0]   in_tap1,
	input  logic signed [SAMPLE_BITS-1:0]   in_tap2,
	input  logic signed [HIST_W-1:0]        out_tap1,
	input  logic signed [HIST_W-1:0]        out_tap2,
	output logic signed [SAMPLE_BITS-1:0]   filtered,
	output logic signed [HIST_W-1:0]        hist,
	output logic                            hit,
	output logic signed [HIST_W-1:0]        prime_hist
);

	localparam int PW = COEF_W + SAMPLE_BITS;

	localparam logic signed [ACC_W-1:0] ACC_MAX  = ACC_W'(1) << ACC_LIM_BIT;
	localparam logic signed [ACC_W-1:0] ACC_MIN  = -ACC_MAX;
	localparam logic signed [ACC_W-1:0] HIST_MAX = (ACC_W'(1) << (HIST_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] HIST_MIN = -HIST_MAX - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SMAX = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] Y_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

	logic signed [PW-1:0]         p_b0, p_b1, p_b2;
	logic signed [2*COEF_W-1:0]   p_a1, p_a2;
	logic signed [2*COEF_W-1:0]   fb1, fb2;
	logic signed [ACC_W-1:0]      acc_full, acc, hist_raw, y_raw, y_sat, hist_sat;
	logic signed [ACC_W-1:0]      prime_raw, prime_sat;
	logic                         acc_hit, hist_hit, y_hit;

	assign p_b0 = coef.b0 * sample;
	assign p_b1 = coef.b1 * in_tap1;
	assign p_b2 = coef.b2 * in_tap2;
	assign p_a1 = coef.a1 * out_tap1;
	assign p_a2 = coef.a2 * out_tap2;

	// feedback terms are Q.(F+16), floor them back to Q.F
	assign fb1 = p_a1 >>> HIST_FRAC;
	assign fb2 = p_a2 >>> HIST_FRAC;

	assign acc_full = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
		- ACC_W'(fb1) - ACC_W'(fb2);

	always_comb begin
		acc_hit = 1'b0;
		acc     = acc_full;
		if (acc_full > ACC_MAX) begin
			acc_hit = 1'b1;
			acc     = ACC_MAX;
		end else if (acc_full < ACC_MIN) begin
			acc_hit = 1'b1;
			acc     = ACC_MIN;
		end
	end

	generate
		if (COEF_FRAC_BITS > HIST_FRAC) begin : g_hist_round
			localparam logic signed [ACC_W-1:0] HIST_HALF =
				ACC_W'(1) << (COEF_FRAC_BITS - HIST_FRAC - 1);
			assign hist_raw = (acc + HIST_HALF) >>> (COEF_FRAC_BITS - HIST_FRAC);
		end else begin : g_hist_scale
			assign hist_raw = acc <<< (HIST_FRAC - COEF_FRAC_BITS);
		end
	endgenerate

	// round half up to integer
	assign y_raw = (acc + Y_HALF) >>> COEF_FRAC_BITS;

	always_comb begin
		hist_hit = 1'b0;
		hist_sat = hist_raw;
		if (hist_raw > HIST_MAX) begin
			hist_hit = 1'b1;
			hist_sat = HIST_MAX;
		end else if (hist_raw < HIST_MIN) begin
			hist_hit = 1'b1;
			hist_sat = HIST_MIN;
		end
	end

	always_comb begin
		y_hit = 1'b0;
		y_sat = y_raw;
		if (y_raw > SMAX) begin
			y_hit = 1'b1;
			y_sat = SMAX;
		end else if (y_raw < SMIN) begin
			y_hit = 1'b1;
			y_sat = SMIN;
		end
	end

	// prime loads the sample as Q16.16
	assign prime_raw = ACC_W'(sample) <<< HIST_FRAC;

	always_comb begin
		prime_sat = prime_raw;
		if (prime_raw > HIST_MAX) begin
			prime_sat = HIST_MAX;
		end else if (prime_raw < HIST_MIN) begin
			prime_sat = HIST_MIN;
		end
	end

	assign filtered   = y_sat[SAMPLE_BITS-1:0];
	assign hist       = hist_sat[HIST_W-1:0];
	assign hit        = acc_hit | hist_hit | y_hit;
	assign prime_hist = prime_sat[HIST_W-1:0];

endmodule

[design/biquad_iir_filter_core.sv]
// ----------------------------------------------------------------------------
// biquad_iir_filter_core: second-order direct-form-I IIR filter
// Computes y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2 on signed samples.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid/in_ready) carries command and sample. A prime
//   command loads all four history taps from the sample and gives no word on
//   the output; a filter command gives one word: filtered (rounded, saturated)
//   and clipped (set when the sum, output or stored history saturated).
//   output channel (out_valid/out_ready) delivers result words in order.
//   config channel (cfg_valid/cfg_ready) writes coefficient cfg_index with
//   cfg_data; it is always ready and is meant to be used while idle.
// Timing:
//   a word accepted sits in the input register, is computed and, if a filter
//   command, lands in the output register once that register is free.
//   One word per cycle while the receiver keeps up, set by the combinational
//   loop of five multiplies and the sum that feeds the output history back.
// Reset clears the history taps and both pipeline valids and loads the
// low-pass coefficient set. When the receiver stalls, the output register
// holds its word and the input register takes words until it holds a filter one.
// ----------------------------------------------------------------------------
module biquad_iir_filter_core
	import bq_pkg::*;
#(
	parameter int SAMPLE_BITS    = 16,
	parameter int COEF_FRAC_BITS = 30
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] filtered,
	output logic                          clipped,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [COEF_W-1:0]             cfg_data
);

	bq_coef_t                      coef;
	logic                          valid_s1;
	logic                          command_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic signed [SAMPLE_BITS-1:0] in_tap1_q, in_tap2_q;
	logic signed [HIST_W-1:0]      out_tap1_q, out_tap2_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] filtered_q;
	logic                          clipped_q;
	logic signed [SAMPLE_BITS-1:0] dp_filtered;
	logic signed [HIST_W-1:0]      dp_hist, dp_prime_hist;
	logic                          dp_hit;
	logic                          out_free, advance, in_fire;

	assign cfg_ready = 1'b1;

	bq_coef_regs u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.coef     (coef)
	);

	bq_datapath #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.coef       (coef),
		.sample     (sample_s1),
		.in_tap1    (in_tap1_q),
		.in_tap2    (in_tap2_q),
		.out_tap1   (out_tap1_q),
		.out_tap2   (out_tap2_q),
		.filtered   (dp_filtered),
		.hist       (dp_hist),
		.hit        (dp_hit),
		.prime_hist (dp_prime_hist)
	);

	// a prime word needs no room in the output register
	assign out_free = ~out_valid_q | out_ready;
	assign advance  = valid_s1 & ((command_s1 == CMD_PRIME) | out_free);
	assign in_ready = ~valid_s1 | advance;
	assign in_fire  = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			command_s1 <= command;
			sample_s1  <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tap1_q  <= '0;
			in_tap2_q  <= '0;
			out_tap1_q <= '0;
			out_tap2_q <= '0;
		end else if (advance) begin
			if (command_s1 == CMD_PRIME) begin
				in_tap1_q  <= sample_s1;
				in_tap2_q  <= sample_s1;
				out_tap1_q <= dp_prime_hist;
				out_tap2_q <= dp_prime_hist;
			end else begin
				in_tap1_q  <= sample_s1;
				in_tap2_q  <= in_tap1_q;
				out_tap1_q <= dp_hist;
				out_tap2_q <= out_tap1_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && command_s1 == CMD_FILTER) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && command_s1 == CMD_FILTER) begin
			filtered_q <= dp_filtered;
			clipped_q  <= dp_hit;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;
	assign clipped   = clipped_q;

endmodule
